/* sv/drfft_pkg.sv */
// Package for dual_real_fft: Q2.15 twiddle table, widths and sequencer states.
// No dependencies.
`default_nettype none
package drfft_pkg;
  localparam int unsigned SampleW = 16;
  localparam int unsigned OutW    = 23;
  localparam int unsigned TwW     = 17;
  localparam int unsigned AccW    = 32;

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_CALC = 4'b0010,
    ST_BIN  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  function automatic logic signed [TwW-1:0] cos_quarter(input logic [4:0] m);
    logic signed [TwW-1:0] r;
    case (m)
      5'd0:  r = 17'sd32768;
      5'd1:  r = 17'sd32610;
      5'd2:  r = 17'sd32138;
      5'd3:  r = 17'sd31356;
      5'd4:  r = 17'sd30273;
      5'd5:  r = 17'sd28899;
      5'd6:  r = 17'sd27246;
      5'd7:  r = 17'sd25330;
      5'd8:  r = 17'sd23170;
      5'd9:  r = 17'sd20788;
      5'd10: r = 17'sd18205;
      5'd11: r = 17'sd15447;
      5'd12: r = 17'sd12540;
      5'd13: r = 17'sd9512;
      5'd14: r = 17'sd6393;
      5'd15: r = 17'sd3212;
      default: r = 17'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [TwW-1:0] cos_q(input logic [5:0] m);
    logic signed [TwW-1:0] r;
    if (m <= 6'd16) r = cos_quarter(m[4:0]);
    else if (m <= 6'd32) r = -cos_quarter(5'(6'd32 - m));
    else if (m <= 6'd48) r = -cos_quarter(5'(m - 6'd32));
    else r = cos_quarter(5'(7'd64 - {1'b0, m}));
    return r;
  endfunction
endpackage
`default_nettype wire

/* sv/dual_real_fft.sv */
// Dual real FFT top level: loads N sample pairs, computes the DFT on one
// shared complex multiply-accumulate unit, splits and emits both spectra.
// Depends on drfft_pkg.
//
// Usage: a transaction on the input side is start high while busy is low;
// it carries sample_a_i and sample_b_i. After FFT_SIZE transactions the block
// goes busy and computes every bin as a direct sum over the stored frame: one
// sample product per cycle through the 17x16 multipliers, then emits FFT_SIZE
// results, one per cycle, each marked by valid_o for one cycle; frame_last_o
// marks the final one. The receiver cannot stall. The loads run one per cycle
// while start is held, and busy stays high through the emit, so no new frame
// is taken until the last one has been emitted. Reset clears the counters and
// state; the sample memory needs no clearing since every entry is written
// before it is read.
`default_nettype none
module dual_real_fft #(
  parameter int unsigned FFT_SIZE = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic signed [drfft_pkg::SampleW-1:0] sample_a_i,
  input  wire logic signed [drfft_pkg::SampleW-1:0] sample_b_i,
  output logic                                    valid_o,
  output logic signed [drfft_pkg::OutW-1:0]       spec_a_part_o,
  output logic signed [drfft_pkg::OutW-1:0]       spec_b_part_o,
  output logic                                    frame_last_o
);
  localparam int unsigned LogN = $clog2(FFT_SIZE);
  localparam int unsigned TwStep = 64 / FFT_SIZE;
  localparam int unsigned SW = drfft_pkg::SampleW;
  localparam int unsigned AW = drfft_pkg::AccW;
  localparam int unsigned PW = drfft_pkg::SampleW + drfft_pkg::TwW + 1;

  drfft_pkg::state_e state_q, state_d;
  logic [LogN-1:0] n_q, k_q, p_q;
  logic            mac_v_q, last_n_q;
  logic [LogN-1:0] kw_q;

  logic signed [SW-1:0] mem_a [FFT_SIZE];
  logic signed [SW-1:0] mem_b [FFT_SIZE];
  logic signed [AW-1:0] bin_r [FFT_SIZE];
  logic signed [AW-1:0] bin_i [FFT_SIZE];

  logic signed [SW-1:0] rd_a_q, rd_b_q;
  logic [5:0]           m_q;
  logic signed [AW-1:0] acc_r_q, acc_i_q;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_q != drfft_pkg::ST_LOAD);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_a[n_q] <= sample_a_i;
      mem_b[n_q] <= sample_b_i;
    end
    rd_a_q <= mem_a[n_q];
    rd_b_q <= mem_b[n_q];
    m_q    <= 6'((32'(n_q) * 32'(k_q) * TwStep) & 32'd63);
  end

  logic signed [drfft_pkg::TwW-1:0] c_tw, s_tw;
  logic signed [PW-1:0] pr, pi;
  logic signed [AW-1:0] rr, ri;
  always_comb begin
    c_tw = drfft_pkg::cos_q(m_q);
    s_tw = drfft_pkg::cos_q(6'(m_q + 6'd48));
    pr = PW'(rd_a_q * c_tw) + PW'(rd_b_q * s_tw) + PW'(16384);
    pi = PW'(rd_b_q * c_tw) - PW'(rd_a_q * s_tw) + PW'(16384);
    rr = AW'(pr >>> 15);
    ri = AW'(pi >>> 15);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      drfft_pkg::ST_LOAD: if (accept && n_q == LogN'(FFT_SIZE - 1)) state_d = drfft_pkg::ST_CALC;
      drfft_pkg::ST_CALC: if (n_q == LogN'(FFT_SIZE - 1)) state_d = drfft_pkg::ST_BIN;
      drfft_pkg::ST_BIN: begin
        if (k_q == LogN'(FFT_SIZE - 1)) state_d = drfft_pkg::ST_EMIT;
        else state_d = drfft_pkg::ST_CALC;
      end
      drfft_pkg::ST_EMIT: if (p_q == LogN'(FFT_SIZE - 1)) state_d = drfft_pkg::ST_LOAD;
      default: state_d = drfft_pkg::ST_LOAD;
    endcase
  end

  // ST_BIN lets the two-stage pipeline (read, multiply) drain the last product of a bin
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= drfft_pkg::ST_LOAD;
      n_q      <= '0;
      k_q      <= '0;
      p_q      <= '0;
      mac_v_q  <= 1'b0;
      last_n_q <= 1'b0;
      kw_q     <= '0;
    end else begin
      state_q  <= state_d;
      mac_v_q  <= (state_q == drfft_pkg::ST_CALC);
      last_n_q <= (state_q == drfft_pkg::ST_CALC) && n_q == LogN'(FFT_SIZE - 1);
      kw_q     <= k_q;
      case (state_q)
        drfft_pkg::ST_LOAD: if (accept) n_q <= n_q + 1'b1;
        drfft_pkg::ST_CALC: n_q <= n_q + 1'b1;
        drfft_pkg::ST_BIN:  k_q <= k_q + 1'b1;
        drfft_pkg::ST_EMIT: p_q <= p_q + 1'b1;
        default: ;
      endcase
    end
  end

  // accumulator works in the cycle after the read address, on the registered read data
  always_ff @(posedge clk_i) begin
    if (mac_v_q) begin
      if (last_n_q) begin
        bin_r[kw_q] <= acc_r_q + rr;
        bin_i[kw_q] <= acc_i_q + ri;
        acc_r_q <= '0;
        acc_i_q <= '0;
      end else begin
        acc_r_q <= acc_r_q + rr;
        acc_i_q <= acc_i_q + ri;
      end
    end else if (state_q == drfft_pkg::ST_LOAD) begin
      acc_r_q <= '0;
      acc_i_q <= '0;
    end
  end

  logic [LogN-1:0] kk, qq;
  logic signed [AW-1:0] va, vb;
  always_comb begin
    kk = p_q;
    if (p_q > LogN'(FFT_SIZE / 2)) kk = p_q - LogN'(FFT_SIZE / 2);
    qq = LogN'(0) - kk;
    if (p_q == '0 || p_q == LogN'(FFT_SIZE / 2)) begin
      va = bin_r[kk] <<< 1;
      vb = bin_i[kk] <<< 1;
    end else if (p_q < LogN'(FFT_SIZE / 2)) begin
      va = bin_r[kk] + bin_r[qq];
      vb = bin_i[kk] + bin_i[qq];
    end else begin
      va = bin_i[kk] - bin_i[qq];
      vb = bin_r[qq] - bin_r[kk];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o      <= 1'b0;
      frame_last_o <= 1'b0;
    end else begin
      valid_o      <= (state_q == drfft_pkg::ST_EMIT);
      frame_last_o <= (state_q == drfft_pkg::ST_EMIT) && p_q == LogN'(FFT_SIZE - 1);
    end
  end

  always_ff @(posedge clk_i) begin
    spec_a_part_o <= va[drfft_pkg::OutW-1:0];
    spec_b_part_o <= vb[drfft_pkg::OutW-1:0];
  end
endmodule
`default_nettype wire

/* sv/drfft_checker.sv */
// Port-level checker for dual_real_fft, bound to the top level.
// Depends on dual_real_fft ports only.
`default_nettype none
module drfft_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic valid_o,
  input wire logic frame_last_o
);
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_last_o |-> valid_o) else $error("last without valid");
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !frame_last_o |-> busy) else $error("valid while idle");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_last_o |=> !valid_o) else $error("result after last");
endmodule

bind dual_real_fft drfft_checker u_drfft_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
  .valid_o(valid_o), .frame_last_o(frame_last_o)
);
`default_nettype wire

/* tb/tb_dual_real_fft.sv */
// Testbench for dual_real_fft: drives sample-pair frames, predicts both real
// spectra by a direct fixed-point DFT and checks each result in order.
// Depends on drfft_pkg and dual_real_fft.
`default_nettype none
module tb_dual_real_fft;
  localparam int unsigned N = 32;
  localparam int unsigned TW_STEP = 64 / N;
  localparam int unsigned FRAME_CYCLES = N * N + 2 * N + 16;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [drfft_pkg::OutW-1:0] spec_a;
    logic signed [drfft_pkg::OutW-1:0] spec_b;
    logic                              last;
  } spec_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [drfft_pkg::SampleW-1:0] sample_a_i = '0;
  logic signed [drfft_pkg::SampleW-1:0] sample_b_i = '0;
  logic valid_o;
  logic signed [drfft_pkg::OutW-1:0] spec_a_part_o;
  logic signed [drfft_pkg::OutW-1:0] spec_b_part_o;
  logic frame_last_o;

  dual_real_fft #(.FFT_SIZE(N)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .sample_a_i(sample_a_i), .sample_b_i(sample_b_i), .valid_o(valid_o),
    .spec_a_part_o(spec_a_part_o), .spec_b_part_o(spec_b_part_o),
    .frame_last_o(frame_last_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  longint frame_a[N];
  longint frame_b[N];
  int unsigned fill_idx = 0;
  spec_word_t spectrum_q[$];
  int errors = 0;
  longint cycles = 0;
  bit idle_gaps = 1'b1;

  function automatic longint cos_quarter_val(int unsigned m);
    longint tab[17] = '{32768, 32610, 32138, 31356, 30273, 28899, 27246, 25330,
                        23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};
    return tab[m];
  endfunction

  function automatic longint twiddle_cos(int unsigned m);
    m = m & 63;
    if (m <= 16) return cos_quarter_val(m);
    if (m <= 32) return -cos_quarter_val(32 - m);
    if (m <= 48) return -cos_quarter_val(m - 32);
    return cos_quarter_val(64 - m);
  endfunction

  function automatic longint round_q15(longint v);
    return (v + 16384) >>> 15;
  endfunction

  task automatic predict_spectra();
    longint wr[N];
    longint wi[N];
    longint sr, si, c, s, va, vb;
    int unsigned m, q, kk;
    spec_word_t w;
    for (int k = 0; k < N; k++) begin
      sr = 0;
      si = 0;
      for (int n = 0; n < N; n++) begin
        m = (n * k * TW_STEP) & 63;
        c = twiddle_cos(m);
        s = twiddle_cos((m + 48) & 63);
        sr += round_q15(frame_a[n] * c + frame_b[n] * s);
        si += round_q15(frame_b[n] * c - frame_a[n] * s);
      end
      wr[k] = sr;
      wi[k] = si;
    end
    for (int p = 0; p < N; p++) begin
      if (p == 0 || p == N / 2) begin
        va = 2 * wr[p];
        vb = 2 * wi[p];
      end else if (p < N / 2) begin
        q = N - p;
        va = wr[p] + wr[q];
        vb = wi[p] + wi[q];
      end else begin
        kk = p - N / 2;
        q = N - kk;
        va = wi[kk] - wi[q];
        vb = wr[q] - wr[kk];
      end
      w.spec_a = va[drfft_pkg::OutW-1:0];
      w.spec_b = vb[drfft_pkg::OutW-1:0];
      w.last = (p == N - 1);
      spectrum_q.push_back(w);
    end
  endtask

  task automatic send_pair(input logic signed [drfft_pkg::SampleW-1:0] a,
                           input logic signed [drfft_pkg::SampleW-1:0] b);
    while (idle_gaps && $urandom_range(99) < 10) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    sample_a_i <= a;
    sample_b_i <= b;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    frame_a[fill_idx] = a;
    frame_b[fill_idx] = b;
    fill_idx++;
    if (fill_idx == N) begin
      fill_idx = 0;
      predict_spectra();
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (spectrum_q.size() != 0);
  endtask

  always @(posedge clk_i) begin
    spec_word_t w;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
    if (rst_ni && valid_o) begin
      if (spectrum_q.size() == 0) begin
        $error("spectrum word with no transaction pending");
        errors++;
      end else begin
        w = spectrum_q.pop_front();
        if (spec_a_part_o !== w.spec_a) begin
          $error("spec_a_part expected %0d actual %0d", w.spec_a, spec_a_part_o);
          errors++;
        end
        if (spec_b_part_o !== w.spec_b) begin
          $error("spec_b_part expected %0d actual %0d", w.spec_b, spec_b_part_o);
          errors++;
        end
        if (frame_last_o !== w.last) begin
          $error("frame_last expected %0d actual %0d", w.last, frame_last_o);
          errors++;
        end
      end
    end
  end

  task automatic test_extremes();
    logic signed [drfft_pkg::SampleW-1:0] ext[4] = '{16'sh7FFF, -16'sh8000, 16'sd0, -16'sd1};
    for (int i = 0; i < N; i++) send_pair(ext[i % 4], ext[(i + 1) % 4]);
  endtask

  task automatic test_impulse_and_full_scale();
    for (int i = 0; i < N; i++) send_pair(i == 0 ? 16'sh7FFF : 16'sd0, -16'sh8000);
    wait_drained();
  endtask

  task automatic test_random_frames(input int frames, input bit gaps);
    idle_gaps = gaps;
    for (int f = 0; f < frames; f++) begin
      for (int i = 0; i < N; i++) begin
        if (f % 2) send_pair($urandom_range(1, 0) ? 16'sh7FFF : -16'sh8000,
                             16'($urandom));
        else send_pair(16'($urandom), 16'($urandom));
      end
    end
    idle_gaps = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_impulse_and_full_scale();
    test_random_frames(1, 1'b1);
    test_random_frames(1, 1'b0);
    test_random_frames(1, 1'b1);
    wait_drained();
    repeat (FRAME_CYCLES) @(posedge clk_i);
    if (errors == 0 && spectrum_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
